[rtl/gql_pkg.sv]
// shared types, constants and helpers of the glyph quad layout block
package gql_pkg;

	localparam int CODE_BITS      = 8;
	localparam int GLYPH_DEPTH    = 2 ** CODE_BITS;
	localparam int KERN_AW        = 2 * CODE_BITS;
	localparam int MAX_TEXT_CHARS = 16384;
	localparam int POS_BITS       = $clog2(MAX_TEXT_CHARS);
	localparam logic [POS_BITS-1:0] POS_MAX = POS_BITS'(MAX_TEXT_CHARS - 1);

	localparam logic [1:0] FUNC_GLYPH  = 2'd0;
	localparam logic [1:0] FUNC_KERN   = 2'd1;
	localparam logic [1:0] FUNC_PLACE  = 2'd2;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	localparam logic [1:0] CFG_SCALE    = 2'd0;
	localparam logic [1:0] CFG_BASELINE = 2'd1;
	localparam logic [1:0] CFG_ATLAS_W  = 2'd2;
	localparam logic [1:0] CFG_ATLAS_H  = 2'd3;

	localparam logic [16:0] TEX_ONE = 17'd65536;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_KMUL, ST_KADD, ST_MX1, ST_MY0, ST_MY1,
		ST_MADV, ST_PADV, ST_DIV, ST_DIVW, ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		MUL_KERN, MUL_OX, MUL_OXW, MUL_HOY, MUL_OY, MUL_ADV
	} mul_sel_t;

	typedef enum logic [2:0] {
		ACC_NONE, ACC_PEN, ACC_X0, ACC_X1, ACC_Y0, ACC_Y1
	} acc_sel_t;

	typedef enum logic [1:0] {
		JOB_U0, JOB_V0, JOB_U1, JOB_V1
	} job_t;

	typedef struct packed {
		logic [11:0] ax;
		logic [11:0] ay;
		logic [7:0]  w;
		logic [7:0]  h;
		logic [7:0]  ox;
		logic [7:0]  oy;
		logic [7:0]  adv;
	} glyph_t;

	typedef struct packed {
		logic     accept;
		logic     clr_en;
		mul_sel_t mul_sel;
		acc_sel_t acc_sel;
		logic     div_start;
		logic     div_store;
		job_t     div_job;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic div_done;
	} sts_t;

	// pen sum to 24 bit signed
	function automatic logic signed [23:0] sat_pen(input logic signed [27:0] v);
		logic signed [23:0] r;
		if (v > 28'sd8388607) r = 24'sh7FFFFF;
		else if (v < -28'sd8388608) r = 24'sh800000;
		else r = v[23:0];
		return r;
	endfunction

	// q.8 to q12.4, round half up, saturate
	function automatic logic [15:0] to_q4(input logic signed [27:0] v);
		logic signed [28:0] t;
		logic signed [24:0] q;
		logic [15:0] r;
		t = 29'(v) + 29'sd8;
		q = 25'(t >>> 4);
		if (q > 25'sd32767) r = 16'h7FFF;
		else if (q < -25'sd32768) r = 16'h8000;
		else r = q[15:0];
		return r;
	endfunction

endpackage

[rtl/gql_div.sv]
// radix-4 restoring divider for rounded q1.16 texture ratios
module gql_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [12:0] num,
	input  logic [12:0] den,
	output logic        done,
	output logic [16:0] result
);
	import gql_pkg::*;

	logic [12:0] rem_q;
	logic [12:0] den_q;
	logic [17:0] quo_q;
	logic [3:0]  cnt_q;
	logic        sat_q;
	logic        done_q;
	logic [13:0] r1;
	logic [13:0] r2;
	logic [12:0] rm1;
	logic [12:0] rm2;
	logic        b1;
	logic        b2;
	logic [17:0] half_q;

	// two quotient bits per cycle
	always_comb begin
		r1  = {rem_q, 1'b0};
		b1  = r1 >= {1'b0, den_q};
		rm1 = b1 ? 13'(r1 - {1'b0, den_q}) : r1[12:0];
		r2  = {rm1, 1'b0};
		b2  = r2 >= {1'b0, den_q};
		rm2 = b2 ? 13'(r2 - {1'b0, den_q}) : r2[12:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
			sat_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				sat_q <= num >= den;
				cnt_q <= (num >= den) ? 4'd0 : 4'd9;
				done_q <= num >= den;
			end else if (cnt_q != 4'd0) begin
				cnt_q <= cnt_q - 4'd1;
				done_q <= cnt_q == 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (cnt_q != 4'd0) begin
			rem_q <= rm2;
			quo_q <= {quo_q[15:0], b1, b2};
		end
	end

	// floor(n*2^18/d) -> round half up at 2^16
	assign half_q = {1'b0, quo_q[17:1]} + 18'd1;
	assign result = sat_q ? TEX_ONE : half_q[17:1];
	assign done   = done_q;

endmodule

[rtl/gql_ctrl.sv]
// sequencing state machine of the glyph quad layout block
module gql_ctrl (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic [1:0]   func,
	input  logic         out_ready,
	input  gql_pkg::sts_t sts,
	output logic         in_ready,
	output logic         out_valid,
	output gql_pkg::cmd_t cmd
);
	import gql_pkg::*;

	state_t state_q, state_d;
	job_t   job_q, job_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			job_q       <= JOB_U0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			job_q   <= job_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d       = state_q;
		job_d         = job_q;
		in_ready      = 1'b0;
		cmd           = '0;
		cmd.mul_sel   = MUL_KERN;
		cmd.acc_sel   = ACC_NONE;
		cmd.div_job   = job_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid && func == FUNC_PLACE) state_d = ST_KMUL;
			end
			ST_KMUL: begin
				cmd.mul_sel = MUL_KERN;
				state_d     = ST_KADD;
			end
			ST_KADD: begin
				cmd.acc_sel = ACC_PEN;
				cmd.mul_sel = MUL_OX;
				state_d     = ST_MX1;
			end
			ST_MX1: begin
				cmd.acc_sel = ACC_X0;
				cmd.mul_sel = MUL_OXW;
				state_d     = ST_MY0;
			end
			ST_MY0: begin
				cmd.acc_sel = ACC_X1;
				cmd.mul_sel = MUL_HOY;
				state_d     = ST_MY1;
			end
			ST_MY1: begin
				cmd.acc_sel = ACC_Y0;
				cmd.mul_sel = MUL_OY;
				state_d     = ST_MADV;
			end
			ST_MADV: begin
				cmd.acc_sel = ACC_Y1;
				cmd.mul_sel = MUL_ADV;
				state_d     = ST_PADV;
			end
			ST_PADV: begin
				cmd.acc_sel = ACC_PEN;
				job_d       = JOB_U0;
				state_d     = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIVW;
			end
			ST_DIVW: begin
				if (sts.div_done) begin
					cmd.div_store = 1'b1;
					if (job_q == JOB_V1) begin
						state_d = ST_OUT;
					end else begin
						job_d   = job_t'(job_q + 2'd1);
						state_d = ST_DIV;
					end
				end
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

[rtl/gql_datapath.sv]
// tables, pen, shared multiplier, divider and result registers
module gql_datapath (
	input  logic          clk,
	input  logic          arst_n,
	input  gql_pkg::cmd_t cmd,
	output gql_pkg::sts_t sts,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [15:0]   cfg_data,
	input  logic [1:0]    func,
	input  logic [7:0]    code,
	input  logic [7:0]    prior_code,
	input  logic [11:0]   atlas_x,
	input  logic [11:0]   atlas_y,
	input  logic [7:0]    glyph_width,
	input  logic [7:0]    glyph_height,
	input  logic signed [7:0] offset_x,
	input  logic signed [7:0] offset_y,
	input  logic [7:0]    advance,
	input  logic signed [7:0] kern_value,
	input  logic          first_in_text,
	output logic signed [15:0] quad_x0,
	output logic signed [15:0] quad_y0,
	output logic signed [15:0] quad_x1,
	output logic signed [15:0] quad_y1,
	output logic [16:0]   tex_u0,
	output logic [16:0]   tex_v0,
	output logic [16:0]   tex_u1,
	output logic [16:0]   tex_v1,
	output logic [15:0]   vertex_base
);
	import gql_pkg::*;

	glyph_t      glyph_mem [GLYPH_DEPTH];
	logic [7:0]  kern_mem  [2**KERN_AW];
	glyph_t      glyph_rd_q;
	logic [7:0]  kern_rd_q;

	logic [15:0] scale_q;
	logic [15:0] baseline_q;
	logic [12:0] atlas_w_q;
	logic [12:0] atlas_h_q;

	logic [KERN_AW-1:0]   clr_cnt_q;
	logic signed [23:0]   pen_q;
	logic [CODE_BITS-1:0] last_code_q;
	logic [CODE_BITS-1:0] code_q;
	logic [POS_BITS-1:0]  pos_q;
	logic                 first_q;

	logic signed [26:0] prod_q;
	logic signed [26:0] prod_c;
	logic signed [16:0] s_ext;
	logic signed [9:0]  opnd;
	logic signed [9:0]  ox_e;
	logic signed [9:0]  oy_e;
	logic signed [27:0] pen_sum;
	logic signed [27:0] base_dif;

	logic [15:0] x0_q, x1_q, y0_q, y1_q;
	logic [16:0] u0_q, v0_q, u1_q, v1_q;
	logic [15:0] qx0_q, qy0_q, qx1_q, qy1_q;
	logic [16:0] tu0_q, tv0_q, tu1_q, tv1_q;
	logic [15:0] vb_q;

	logic [12:0] div_num;
	logic [12:0] div_den;
	logic [12:0] den_raw;
	logic        div_done;
	logic [16:0] div_res;
	logic [16:0] one_minus;

	logic                 place;
	logic [CODE_BITS-1:0] in_code;
	logic [KERN_AW-1:0]   kern_waddr;
	logic                 kern_we;

	assign in_code = code[CODE_BITS-1:0];
	assign place   = cmd.accept && func == FUNC_PLACE;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q    <= 16'd256;
			baseline_q <= '0;
			atlas_w_q  <= 13'd256;
			atlas_h_q  <= 13'd256;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SCALE:    scale_q    <= cfg_data;
				CFG_BASELINE: baseline_q <= cfg_data;
				CFG_ATLAS_W:  atlas_w_q  <= cfg_data[12:0];
				CFG_ATLAS_H:  atlas_h_q  <= cfg_data[12:0];
				default:      scale_q    <= scale_q;
			endcase
		end
	end

	// glyph table, read on every accepted request
	always_ff @(posedge clk) begin
		if (cmd.accept && func == FUNC_GLYPH) begin
			glyph_mem[in_code] <= '{ax: atlas_x, ay: atlas_y, w: glyph_width,
				h: glyph_height, ox: offset_x, oy: offset_y, adv: advance};
		end
		if (cmd.accept) glyph_rd_q <= glyph_mem[in_code];
	end

	// kerning table, zeroed by the clearing sweep
	assign kern_we    = cmd.clr_en || (cmd.accept && func == FUNC_KERN);
	assign kern_waddr = cmd.clr_en ? clr_cnt_q :
		{prior_code[CODE_BITS-1:0], in_code};

	always_ff @(posedge clk) begin
		if (kern_we) kern_mem[kern_waddr] <= cmd.clr_en ? 8'd0 : kern_value;
		if (cmd.accept) kern_rd_q <= kern_mem[{last_code_q, in_code}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_cnt_q <= '0;
		else if (cmd.clr_en) clr_cnt_q <= clr_cnt_q + 1'b1;
	end
	assign sts.clr_last = &clr_cnt_q;

	// shared multiplier: scale times a small font-pixel operand
	assign ox_e  = {{2{glyph_rd_q.ox[7]}}, glyph_rd_q.ox};
	assign oy_e  = {{2{glyph_rd_q.oy[7]}}, glyph_rd_q.oy};
	assign s_ext = {1'b0, scale_q};

	always_comb begin
		case (cmd.mul_sel)
			MUL_KERN: opnd = first_q ? 10'sd0 : {{2{kern_rd_q[7]}}, kern_rd_q};
			MUL_OX:   opnd = ox_e;
			MUL_OXW:  opnd = ox_e + $signed({2'b0, glyph_rd_q.w});
			MUL_HOY:  opnd = $signed({2'b0, glyph_rd_q.h}) + oy_e;
			MUL_OY:   opnd = oy_e;
			MUL_ADV:  opnd = $signed({2'b0, glyph_rd_q.adv});
			default:  opnd = 10'sd0;
		endcase
	end
	assign prod_c = s_ext * opnd;

	always_ff @(posedge clk) begin
		prod_q <= prod_c;
	end

	assign pen_sum  = 28'(pen_q) + 28'(prod_q);
	assign base_dif = 28'($signed({baseline_q, 4'b0})) - 28'(prod_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_q       <= '0;
			pos_q       <= '0;
			last_code_q <= '0;
		end else begin
			if (place && first_in_text) begin
				pen_q <= '0;
				pos_q <= '0;
			end else if (cmd.acc_sel == ACC_PEN) begin
				pen_q <= sat_pen(pen_sum);
			end
			if (cmd.out_load) begin
				last_code_q <= code_q;
				if (pos_q < POS_MAX) pos_q <= pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (place) begin
			code_q  <= in_code;
			first_q <= first_in_text;
		end
		case (cmd.acc_sel)
			ACC_X0:  x0_q <= to_q4(pen_sum);
			ACC_X1:  x1_q <= to_q4(pen_sum);
			ACC_Y0:  y0_q <= to_q4(base_dif);
			ACC_Y1:  y1_q <= to_q4(base_dif);
			default: x0_q <= x0_q;
		endcase
	end

	// texture ratio operands
	always_comb begin
		case (cmd.div_job)
			JOB_U0: begin
				div_num = {1'b0, glyph_rd_q.ax};
				den_raw = atlas_w_q;
			end
			JOB_V0: begin
				div_num = {1'b0, glyph_rd_q.ay} + {5'b0, glyph_rd_q.h};
				den_raw = atlas_h_q;
			end
			JOB_U1: begin
				div_num = {1'b0, glyph_rd_q.ax} + {5'b0, glyph_rd_q.w};
				den_raw = atlas_w_q;
			end
			JOB_V1: begin
				div_num = {1'b0, glyph_rd_q.ay};
				den_raw = atlas_h_q;
			end
			default: begin
				div_num = '0;
				den_raw = atlas_w_q;
			end
		endcase
		div_den = (den_raw == 13'd0) ? 13'd1 : den_raw;
	end

	gql_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.result (div_res)
	);
	assign sts.div_done = div_done;
	assign one_minus    = TEX_ONE - div_res;

	always_ff @(posedge clk) begin
		if (cmd.div_store) begin
			case (cmd.div_job)
				JOB_U0:  u0_q <= div_res;
				JOB_V0:  v0_q <= one_minus;
				JOB_U1:  u1_q <= div_res;
				JOB_V1:  v1_q <= one_minus;
				default: u0_q <= div_res;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			qx0_q <= x0_q;
			qy0_q <= y0_q;
			qx1_q <= x1_q;
			qy1_q <= y1_q;
			tu0_q <= u0_q;
			tv0_q <= v0_q;
			tu1_q <= u1_q;
			tv1_q <= v1_q;
			vb_q  <= 16'({pos_q, 2'b00});
		end
	end

	assign quad_x0     = qx0_q;
	assign quad_y0     = qy0_q;
	assign quad_x1     = qx1_q;
	assign quad_y1     = qy1_q;
	assign tex_u0      = tu0_q;
	assign tex_v0      = tv0_q;
	assign tex_u1      = tu1_q;
	assign tex_v1      = tv1_q;
	assign vertex_base = vb_q;

endmodule

[rtl/glyph_quad_layout.sv]
// top level of the bitmap font glyph quad layout block
//
// channel   direction  handshake            contents
// cfg       in         cfg_we               cfg_index, cfg_data (scale, baseline, atlas size)
// in        in         in_valid/in_ready    func, code, glyph metrics, kerning, first flag
// out       out        out_valid/out_ready  quad corners, texture coordinates, vertex base
//
// glyph and kerning writes complete without leaving the idle state; a place request
// runs six passes through the shared multiplier and then four serial divisions
// at two quotient bits per cycle (a ratio of one or more finishes at once)
// after reset the kerning memory is zeroed one entry a cycle, all 65536 entries,
// with in_ready low; configuration writes are taken throughout
// a finished result waits in the output register while the next request is taken;
// a place request stalls only in its final result-load state while that register is full
module glyph_quad_layout (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [7:0]  code,
	input  logic [7:0]  prior_code,
	input  logic [11:0] atlas_x,
	input  logic [11:0] atlas_y,
	input  logic [7:0]  glyph_width,
	input  logic [7:0]  glyph_height,
	input  logic signed [7:0] offset_x,
	input  logic signed [7:0] offset_y,
	input  logic [7:0]  advance,
	input  logic signed [7:0] kern_value,
	input  logic        first_in_text,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [15:0] quad_x0,
	output logic signed [15:0] quad_y0,
	output logic signed [15:0] quad_x1,
	output logic signed [15:0] quad_y1,
	output logic [16:0] tex_u0,
	output logic [16:0] tex_v0,
	output logic [16:0] tex_u1,
	output logic [16:0] tex_v1,
	output logic [15:0] vertex_base
);
	import gql_pkg::*;

	// commands from the sequencer, status back from the datapath
	cmd_t cmd;
	sts_t sts;

	// controller: clearing sweep, multiply sequence, divider jobs, result load
	gql_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.func      (func),
		.out_ready (out_ready),
		.sts       (sts),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	// datapath: glyph and kerning memories, pen, multiplier, divider, result register
	gql_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.func          (func),
		.code          (code),
		.prior_code    (prior_code),
		.atlas_x       (atlas_x),
		.atlas_y       (atlas_y),
		.glyph_width   (glyph_width),
		.glyph_height  (glyph_height),
		.offset_x      (offset_x),
		.offset_y      (offset_y),
		.advance       (advance),
		.kern_value    (kern_value),
		.first_in_text (first_in_text),
		.quad_x0       (quad_x0),
		.quad_y0       (quad_y0),
		.quad_x1       (quad_x1),
		.quad_y1       (quad_y1),
		.tex_u0        (tex_u0),
		.tex_v0        (tex_v0),
		.tex_u1        (tex_u1),
		.tex_v1        (tex_v1),
		.vertex_base   (vertex_base)
	);

	// no request is taken while the kerning memory is being cleared
	a_no_req_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_en |-> !in_ready)
		else $error("request port open during kerning clear");

	// a new result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || out_ready))
		else $error("result register overwritten");

	// a place request closes the request port on the next cycle
	a_place_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && func == FUNC_PLACE) |=> !in_ready)
		else $error("request taken during place");

	// texture coordinates never exceed one
	a_tex_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (tex_u0 <= TEX_ONE && tex_v0 <= TEX_ONE &&
			tex_u1 <= TEX_ONE && tex_v1 <= TEX_ONE))
		else $error("texture coordinate out of range");

endmodule

[tb/sv/glyph_quad_checker.sv]
// checker for the glyph quad layout: predicts each placed quad and compares results
`timescale 1ns / 1ps

module glyph_quad_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  func,
	input  logic [7:0]  code,
	input  logic [7:0]  prior_code,
	input  logic [11:0] atlas_x,
	input  logic [11:0] atlas_y,
	input  logic [7:0]  glyph_width,
	input  logic [7:0]  glyph_height,
	input  logic signed [7:0] offset_x,
	input  logic signed [7:0] offset_y,
	input  logic [7:0]  advance,
	input  logic signed [7:0] kern_value,
	input  logic        first_in_text,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic signed [15:0] quad_x0,
	input  logic signed [15:0] quad_y0,
	input  logic signed [15:0] quad_x1,
	input  logic signed [15:0] quad_y1,
	input  logic [16:0] tex_u0,
	input  logic [16:0] tex_v0,
	input  logic [16:0] tex_u1,
	input  logic [16:0] tex_v1,
	input  logic [15:0] vertex_base,
	output int          fail_count,
	output int          pending_count
);
	import gql_pkg::*;

	typedef struct {
		longint ax, ay, w, h, ox, oy, adv;
	} metrics_t;

	typedef struct {
		logic [15:0] x0, y0, x1, y1;
		logic [16:0] u0, v0, u1, v1;
		logic [15:0] vb;
	} quad_t;

	localparam longint PEN_HI = 64'sd8388607;
	localparam longint PEN_LO = -64'sd8388608;

	metrics_t           glyphs [GLYPH_DEPTH];
	logic signed [7:0]  kerns [2 ** KERN_AW];
	longint             pen;
	logic [7:0]         prev_code;
	int                 char_pos;
	longint             scale, baseline, atlas_w, atlas_h;
	quad_t              quads_due[$];

	initial pending_count = 0;

	function automatic longint clamp(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// q.8 to q12.4: round half up, floor via arithmetic shift
	function automatic logic [15:0] corner_q4(longint v);
		longint q;
		q = clamp((v + 8) >>> 4, -32768, 32767);
		return q[15:0];
	endfunction

	function automatic longint tex_ratio(longint num, longint den);
		longint d, r;
		d = den == 0 ? 1 : den;
		r = (num * 131072 + d) / (2 * d);
		return r > 65536 ? 65536 : r;
	endfunction

	function automatic longint flip(longint t);
		return t >= 65536 ? 0 : 65536 - t;
	endfunction

	task automatic report(string field, longint got, longint want);
		$display("mismatch %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
		fail_count++;
	endtask

	task automatic place_quad(logic [7:0] c, logic first);
		metrics_t g;
		quad_t    q;
		longint   base;
		if (first) begin
			pen      = 0;
			char_pos = 0;
		end else begin
			pen = clamp(pen + scale * longint'(kerns[{prev_code, c}]), PEN_LO, PEN_HI);
		end
		g    = glyphs[c];
		base = baseline * 16;
		q.x0 = corner_q4(pen + scale * g.ox);
		q.x1 = corner_q4(pen + scale * (g.ox + g.w));
		q.y0 = corner_q4(base - scale * (g.h + g.oy));
		q.y1 = corner_q4(base - scale * g.oy);
		q.u0 = 17'(tex_ratio(g.ax, atlas_w));
		q.v0 = 17'(flip(tex_ratio(g.ay + g.h, atlas_h)));
		q.u1 = 17'(tex_ratio(g.ax + g.w, atlas_w));
		q.v1 = 17'(flip(tex_ratio(g.ay, atlas_h)));
		q.vb = 16'(char_pos * 4);
		quads_due.push_back(q);
		pen = clamp(pen + scale * g.adv, PEN_LO, PEN_HI);
		if (char_pos < MAX_TEXT_CHARS - 1) char_pos++;
		prev_code = c;
	endtask

	always @(posedge clk) begin
		quad_t w;
		if (!arst_n) begin
			foreach (kerns[i]) kerns[i] = '0;
			foreach (glyphs[i]) glyphs[i] = '{0, 0, 0, 0, 0, 0, 0};
			pen       = 0;
			prev_code = '0;
			char_pos  = 0;
			scale     = 256;
			baseline  = 0;
			atlas_w   = 256;
			atlas_h   = 256;
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SCALE:    scale    = cfg_data;
					CFG_BASELINE: baseline = longint'($signed(cfg_data));
					CFG_ATLAS_W:  atlas_w  = cfg_data[12:0];
					CFG_ATLAS_H:  atlas_h  = cfg_data[12:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (quads_due.size() == 0) begin
					$display("unexpected result at %0t", $realtime);
					fail_count++;
				end else begin
					w = quads_due.pop_front();
					if (quad_x0 !== w.x0) report("quad_x0", quad_x0, $signed(w.x0));
					if (quad_y0 !== w.y0) report("quad_y0", quad_y0, $signed(w.y0));
					if (quad_x1 !== w.x1) report("quad_x1", quad_x1, $signed(w.x1));
					if (quad_y1 !== w.y1) report("quad_y1", quad_y1, $signed(w.y1));
					if (tex_u0 !== w.u0) report("tex_u0", tex_u0, w.u0);
					if (tex_v0 !== w.v0) report("tex_v0", tex_v0, w.v0);
					if (tex_u1 !== w.u1) report("tex_u1", tex_u1, w.u1);
					if (tex_v1 !== w.v1) report("tex_v1", tex_v1, w.v1);
					if (vertex_base !== w.vb) report("vertex_base", vertex_base, w.vb);
				end
			end
			if (in_valid && in_ready) begin
				case (func)
					FUNC_GLYPH: glyphs[code] = '{atlas_x, atlas_y, glyph_width, glyph_height,
						longint'(offset_x), longint'(offset_y), advance};
					FUNC_KERN:  kerns[{prior_code, code}] = kern_value;
					FUNC_PLACE: place_quad(code, first_in_text);
					default: ;
				endcase
			end
		end
		pending_count = quads_due.size();
	end

endmodule

[tb/sv/tb_glyph_quad_layout.sv]
// testbench top for the glyph quad layout: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb_glyph_quad_layout;
	import gql_pkg::*;

	// one request on the input channel
	typedef struct {
		logic [1:0]  func;
		logic [7:0]  code;
		logic [7:0]  prior_code;
		logic [11:0] ax, ay;
		logic [7:0]  w, h;
		logic [7:0]  ox, oy;
		logic [7:0]  adv;
		logic [7:0]  kern;
		logic        first;
	} request_t;

	// covers the kerning clear and roughly 700 places with long stalls
	localparam int CYCLE_LIMIT = 2000000;
	// covers any trailing work after the last quad is back
	localparam int SETTLE      = 80;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  func;
	logic [7:0]  code;
	logic [7:0]  prior_code;
	logic [11:0] atlas_x;
	logic [11:0] atlas_y;
	logic [7:0]  glyph_width;
	logic [7:0]  glyph_height;
	logic signed [7:0] offset_x;
	logic signed [7:0] offset_y;
	logic [7:0]  advance;
	logic signed [7:0] kern_value;
	logic        first_in_text;
	logic        out_valid;
	logic        out_ready;
	logic signed [15:0] quad_x0;
	logic signed [15:0] quad_y0;
	logic signed [15:0] quad_x1;
	logic signed [15:0] quad_y1;
	logic [16:0] tex_u0;
	logic [16:0] tex_v0;
	logic [16:0] tex_u1;
	logic [16:0] tex_v1;
	logic [15:0] vertex_base;
	int          fail_count;
	int          pending_count;

	// glyph entries that hold data; only these get placed
	bit          glyph_loaded [GLYPH_DEPTH];
	// small set of codes so kerning pairs actually hit during placement
	logic [7:0]  font_set [16];
	// when set, neither side inserts gaps
	bit          steady;
	int          stall_left;
	int          cycles;
	request_t    misc_req;

	glyph_quad_layout uut (.*);
	glyph_quad_checker u_checker (.*);

	always #5 clk = ~clk;

	// watchdog on total run length
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// result side back-pressure: mostly short stalls, a few long ones
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready  <= 1'b0;
		end else begin
			stall_left <= pick_gap();
			out_ready  <= 1'b1;
		end
	end

	// every field random, so ignored fields still toggle
	function automatic request_t noise_req();
		request_t r;
		r.func       = 2'($urandom);
		r.code       = 8'($urandom);
		r.prior_code = 8'($urandom);
		r.ax         = 12'($urandom);
		r.ay         = 12'($urandom);
		r.w          = 8'($urandom);
		r.h          = 8'($urandom);
		r.ox         = 8'($urandom);
		r.oy         = 8'($urandom);
		r.adv        = 8'($urandom);
		r.kern       = 8'($urandom);
		r.first      = 1'($urandom);
		return r;
	endfunction

	function automatic request_t glyph_req(logic [7:0] c, int ax, int ay, int w, int h,
			int ox, int oy, int adv);
		request_t r;
		r      = noise_req();
		r.func = FUNC_GLYPH;
		r.code = c;
		r.ax   = 12'(ax);
		r.ay   = 12'(ay);
		r.w    = 8'(w);
		r.h    = 8'(h);
		r.ox   = 8'(ox);
		r.oy   = 8'(oy);
		r.adv  = 8'(adv);
		return r;
	endfunction

	function automatic request_t kern_req(logic [7:0] prev, logic [7:0] c, int k);
		request_t r;
		r            = noise_req();
		r.func       = FUNC_KERN;
		r.prior_code = prev;
		r.code       = c;
		r.kern       = 8'(k);
		return r;
	endfunction

	function automatic request_t place_req(logic [7:0] c, logic first);
		request_t r;
		r       = noise_req();
		r.func  = FUNC_PLACE;
		r.code  = c;
		r.first = first;
		return r;
	endfunction

	// called just after a falling edge; returns just after a falling edge
	task automatic send(request_t r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid      <= 1'b1;
		func          <= r.func;
		code          <= r.code;
		prior_code    <= r.prior_code;
		atlas_x       <= r.ax;
		atlas_y       <= r.ay;
		glyph_width   <= r.w;
		glyph_height  <= r.h;
		offset_x      <= r.ox;
		offset_y      <= r.oy;
		advance       <= r.adv;
		kern_value    <= r.kern;
		first_in_text <= r.first;
		do @(posedge clk); while (!in_ready);
		if (r.func == FUNC_GLYPH) glyph_loaded[r.code] = 1'b1;
		@(negedge clk);
	endtask

	// hold off requests until every quad is back and the block has gone quiet
	task automatic drain();
		in_valid <= 1'b0;
		wait (pending_count == 0);
		@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// all four registers in one burst, write enable held high throughout
	task automatic set_config(logic [15:0] sc, logic [15:0] bl, logic [15:0] aw,
			logic [15:0] ah);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_SCALE;
		cfg_data  <= sc;
		@(negedge clk);
		cfg_index <= CFG_BASELINE;
		cfg_data  <= bl;
		@(negedge clk);
		cfg_index <= CFG_ATLAS_W;
		cfg_data  <= aw;
		@(negedge clk);
		cfg_index <= CFG_ATLAS_H;
		cfg_data  <= ah;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [15:0] rand_atlas();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 16'd1;
		if (r == 1) return 16'd4096;
		if (r == 2) return 16'd0;   // zero atlas size divides as one
		return 16'($urandom_range(1, 4096));
	endfunction

	function automatic logic [15:0] rand_scale();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 16'd0;
		if (r == 1) return 16'hFFFF;
		if (r < 5) return 16'd256;
		if (r < 8) return 16'($urandom_range(32, 1024));
		return 16'($urandom);
	endfunction

	// random request stream: mostly placement of loaded glyphs inside texts
	task automatic random_phase(int n);
		request_t r;
		int       sel;
		logic [7:0] c;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(0, 99);
			c   = ($urandom_range(0, 3) == 0) ? 8'($urandom) : font_set[$urandom_range(0, 15)];
			if (sel < 15) begin
				r = noise_req();
				r.func = FUNC_GLYPH;
				r.code = c;
				// keep glyphs mostly modest so texts run a while before saturating
				if ($urandom_range(0, 3) != 0) begin
					r.w   = 8'($urandom_range(0, 24));
					r.h   = 8'($urandom_range(0, 24));
					r.ox  = 8'($urandom_range(0, 8) - 4);
					r.oy  = 8'($urandom_range(0, 8) - 4);
					r.adv = 8'($urandom_range(0, 20));
				end
			end else if (sel < 27) begin
				r = kern_req(($urandom_range(0, 3) == 0) ? 8'($urandom) :
					font_set[$urandom_range(0, 15)], c, $urandom_range(0, 255) - 128);
			end else if (sel < 96) begin
				if (!glyph_loaded[c]) send(glyph_req(c, $urandom_range(0, 4095),
					$urandom_range(0, 4095), $urandom_range(0, 255), $urandom_range(0, 255),
					$urandom_range(0, 255) - 128, $urandom_range(0, 255) - 128,
					$urandom_range(0, 255)));
				r = place_req(c, $urandom_range(0, 11) == 0);
			end else begin
				// unused selector: no effect, no result
				r = noise_req();
				r.func = FUNC_UNUSED;
			end
			send(r);
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_SCALE;
		cfg_data      = '0;
		in_valid      = 1'b0;
		func          = FUNC_GLYPH;
		code          = '0;
		prior_code    = '0;
		atlas_x       = '0;
		atlas_y       = '0;
		glyph_width   = '0;
		glyph_height  = '0;
		offset_x      = '0;
		offset_y      = '0;
		advance       = '0;
		kern_value    = '0;
		first_in_text = 1'b0;
		out_ready     = 1'b0;
		stall_left    = 0;
		steady        = 1'b0;
		cycles        = 0;
		foreach (font_set[i]) font_set[i] = 8'($urandom);
		font_set[0] = 8'd0;
		font_set[1] = 8'd255;

		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: extremes of glyph metrics and kerning at reset settings
		send(glyph_req(8'd0, 0, 0, 0, 0, 127, -128, 0));
		send(glyph_req(8'd255, 4095, 4095, 255, 255, -128, 127, 255));
		send(glyph_req(8'd65, 100, 37, 12, 18, -3, 5, 14));
		send(kern_req(8'd255, 8'd0, 127));
		send(kern_req(8'd0, 8'd255, -128));
		send(place_req(8'd255, 1'b1));
		send(place_req(8'd0, 1'b0));     // kerning with the previous character
		send(place_req(8'd255, 1'b0));
		send(place_req(8'd65, 1'b0));    // pair never written: zero kerning
		// random load or unused selector; a place here could hit an empty entry
		misc_req = noise_req();
		if (misc_req.func == FUNC_PLACE) misc_req.func = FUNC_UNUSED;
		send(misc_req);
		send(place_req(8'd65, 1'b1));

		// saturating corners, pen saturation, one-pixel atlas
		set_config(16'hFFFF, 16'h8000, 16'd1, 16'd1);
		send(place_req(8'd255, 1'b1));
		send(place_req(8'd255, 1'b0));
		send(place_req(8'd0, 1'b0));
		send(place_req(8'd65, 1'b0));

		// zero scale, top baseline, widest atlas
		set_config(16'd0, 16'h7FFF, 16'd4096, 16'd4096);
		send(place_req(8'd255, 1'b1));
		send(place_req(8'd0, 1'b0));

		// zero atlas size divides as one
		set_config(16'd384, 16'd160, 16'd0, 16'd0);
		send(place_req(8'd65, 1'b1));
		send(place_req(8'd255, 1'b0));

		// load the working font set with random metrics
		set_config(16'd256, 16'd0, 16'd256, 16'd256);
		foreach (font_set[i]) send(glyph_req(font_set[i], $urandom_range(0, 4095),
			$urandom_range(0, 4095), $urandom_range(0, 32), $urandom_range(0, 32),
			$urandom_range(0, 16) - 8, $urandom_range(0, 16) - 8, $urandom_range(0, 24)));

		// random phases, each under its own settings; some without any gaps
		for (int p = 0; p < 10; p++) begin
			set_config(rand_scale(), 16'($urandom), rand_atlas(), rand_atlas());
			steady = ($urandom_range(0, 3) == 0);
			random_phase(50);
			if (p == 4) drain();    // sender waits for every quad mid-phase
			random_phase(55);
		end
		steady = 1'b0;

		drain();
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

[glyph_quad_layout.f]
rtl/gql_pkg.sv
rtl/gql_div.sv
rtl/gql_ctrl.sv
rtl/gql_datapath.sv
rtl/glyph_quad_layout.sv
tb/sv/glyph_quad_checker.sv
tb/sv/tb_glyph_quad_layout.sv
